### design/scam_pkg.sv
// ----------------------------------------------------------------------------
// scam_pkg: shared types and constants for the structure constant multiplier
// Sizes of the algebra, the coefficient table and the multiplier handshake.
// ----------------------------------------------------------------------------
package scam_pkg;

    // algebra dimension and table geometry
    localparam int DIM        = 4;
    localparam int NFIELDS    = 4;
    localparam int TABLE_SIZE = DIM * DIM * DIM;
    localparam int DIM_W      = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int TAB_AW     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    // item field widths
    localparam int WORD_W = 64;
    localparam int HALF_W = WORD_W / 2;
    localparam int IDX_W  = 6;

    // function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_MUL   = 1'b1;

    typedef logic [WORD_W-1:0] t_word;

    // request to the shared multiplier
    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
    } t_mul_req;

    // response from the shared multiplier
    typedef struct packed {
        logic  done;
        t_word prod;
    } t_mul_rsp;

endpackage

### design/scam_if.sv
// ----------------------------------------------------------------------------
// scam_if: item channels of the structure constant multiplier
// Input channel carries writes and multiply operands, output channel products.
// ----------------------------------------------------------------------------
interface scam_in_if;
    import scam_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [IDX_W-1:0]     coef_index;
    t_word                coef_value;
    t_word                x_0;
    t_word                x_1;
    t_word                x_2;
    t_word                x_3;
    t_word                y_0;
    t_word                y_1;
    t_word                y_2;
    t_word                y_3;

    modport source (
        output valid, func, coef_index, coef_value,
        output x_0, x_1, x_2, x_3, y_0, y_1, y_2, y_3,
        input  ready
    );

    modport sink (
        input  valid, func, coef_index, coef_value,
        input  x_0, x_1, x_2, x_3, y_0, y_1, y_2, y_3,
        output ready
    );
endinterface

interface scam_out_if;
    import scam_pkg::*;

    logic  valid;
    logic  ready;
    t_word r_0;
    t_word r_1;
    t_word r_2;
    t_word r_3;

    modport source (
        output valid, r_0, r_1, r_2, r_3,
        input  ready
    );

    modport sink (
        input  valid, r_0, r_1, r_2, r_3,
        output ready
    );
endinterface

### design/structure_constant_algebra_multiply_unit.sv
// ----------------------------------------------------------------------------
// structure_constant_algebra_multiply_unit: algebra product by stored table
// Holds the structure constant table and forms r_i = sum x_j*y_k*c[j][k][i]
// modulo 2^64 with one shared multiply and accumulate path.
//
//   channel   dir   carries
//   i_in      in    func, coef_index, coef_value, x_0..x_3, y_0..y_3
//   o_res     out   r_0..r_3
//
// a table write is taken back to back with other writes
// a multiply item runs each x_j*y_k product and then each coefficient product
// in turn through the iterative 64-bit multiplier before its result item
// i_in is held off from a multiply accept until its result item is taken
// reset clears the table through per-entry valid bits, no clearing sweep
// ----------------------------------------------------------------------------
module structure_constant_algebra_multiply_unit (
    input logic        i_clk,
    input logic        i_rst_n,
    scam_in_if.sink    i_in,
    scam_out_if.source o_res
);
    import scam_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD_START,
        S_PROD_WAIT,
        S_COEF_RD,
        S_COEF_MUL,
        S_COEF_WAIT,
        S_OUT
    } t_state;

    localparam logic [DIM_W-1:0]  I_LAST    = DIM_W'(DIM - 1);
    localparam logic [TAB_AW-1:0] ADDR_LAST = TAB_AW'(TABLE_SIZE - 1);

    t_state              r_state;
    t_word               r_x [DIM];
    t_word               r_y [DIM];
    t_word               r_acc [DIM];
    t_word               r_pair;
    logic [DIM_W-1:0]    r_j;
    logic [DIM_W-1:0]    r_k;
    logic [DIM_W-1:0]    r_i;
    logic [TAB_AW-1:0]   r_addr;
    logic                r_out_valid;

    // coefficient table
    t_word               r_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] r_valid;
    t_word               r_rd_data;
    logic                r_rd_valid;

    t_word               in_x [NFIELDS];
    t_word               in_y [NFIELDS];
    logic                in_fire;
    logic                wr_fire;
    logic                wr_in_range;
    logic [TAB_AW-1:0]   wr_addr;
    t_word               coef;
    t_mul_req            mul_req;
    t_mul_rsp            mul_rsp;

    // input item decode
    always_comb begin
        in_x[0] = i_in.x_0;
        in_x[1] = i_in.x_1;
        in_x[2] = i_in.x_2;
        in_x[3] = i_in.x_3;
        in_y[0] = i_in.y_0;
        in_y[1] = i_in.y_1;
        in_y[2] = i_in.y_2;
        in_y[3] = i_in.y_3;
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;
    assign wr_fire     = in_fire && (i_in.func == FUNC_WRITE);
    assign wr_in_range = (int'(i_in.coef_index) < TABLE_SIZE);
    assign wr_addr     = TAB_AW'(i_in.coef_index);

    // table storage, registered read
    always_ff @(posedge i_clk) begin
        if (wr_fire && wr_in_range) begin
            r_mem[wr_addr] <= i_in.coef_value;
        end
        r_rd_data <= r_mem[r_addr];
    end

    // per-entry valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (wr_fire && wr_in_range) begin
                r_valid[wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[r_addr];
        end
    end

    assign coef = r_rd_valid ? r_rd_data : '0;

    // shared multiplier: x_j*y_k first, then that pair times each coefficient
    always_comb begin
        mul_req.start = (r_state == S_PROD_START) || (r_state == S_COEF_MUL);
        mul_req.a     = (r_state == S_COEF_MUL) ? r_pair : r_x[r_j];
        mul_req.b     = (r_state == S_COEF_MUL) ? coef : r_y[r_k];
    end

    scam_mul64 u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // sequencer over the table in flat index order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && (i_in.func == FUNC_MUL)) begin
                        for (int n = 0; n < DIM; n++) begin
                            r_x[n]   <= (n < NFIELDS) ? in_x[n % NFIELDS] : '0;
                            r_y[n]   <= (n < NFIELDS) ? in_y[n % NFIELDS] : '0;
                            r_acc[n] <= '0;
                        end
                        r_j     <= '0;
                        r_k     <= '0;
                        r_i     <= '0;
                        r_addr  <= '0;
                        r_state <= S_PROD_START;
                    end
                end
                S_PROD_START: r_state <= S_PROD_WAIT;
                S_PROD_WAIT: begin
                    if (mul_rsp.done) begin
                        r_pair  <= mul_rsp.prod;
                        r_state <= S_COEF_RD;
                    end
                end
                S_COEF_RD:  r_state <= S_COEF_MUL;
                S_COEF_MUL: r_state <= S_COEF_WAIT;
                S_COEF_WAIT: begin
                    if (mul_rsp.done) begin
                        r_acc[r_i] <= r_acc[r_i] + mul_rsp.prod;
                        r_addr     <= r_addr + TAB_AW'(1);
                        if (r_i == I_LAST) begin
                            r_i <= '0;
                            if (r_addr == ADDR_LAST) begin
                                r_out_valid <= 1'b1;
                                r_state     <= S_OUT;
                            end else begin
                                r_state <= S_PROD_START;
                                if (r_k == I_LAST) begin
                                    r_k <= '0;
                                    r_j <= r_j + DIM_W'(1);
                                end else begin
                                    r_k <= r_k + DIM_W'(1);
                                end
                            end
                        end else begin
                            r_i     <= r_i + DIM_W'(1);
                            r_state <= S_COEF_RD;
                        end
                    end
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result item, coordinates beyond the dimension read as zero
    assign o_res.valid = r_out_valid;
    assign o_res.r_0   = (0 < DIM) ? r_acc[0 % DIM] : '0;
    assign o_res.r_1   = (1 < DIM) ? r_acc[1 % DIM] : '0;
    assign o_res.r_2   = (2 < DIM) ? r_acc[2 % DIM] : '0;
    assign o_res.r_3   = (3 < DIM) ? r_acc[3 % DIM] : '0;

endmodule

### design/scam_mul64.sv
// ----------------------------------------------------------------------------
// scam_mul64: iterative 64 x 64 multiplier, low 64 bits of the product
// One 32 x 32 multiplier is used for three partial products, then summed.
// ----------------------------------------------------------------------------
module scam_mul64 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scam_pkg::t_mul_req i_req,
    output scam_pkg::t_mul_rsp o_rsp
);
    import scam_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE,
        M_LL,
        M_LH,
        M_HL,
        M_SUM
    } t_mstate;

    t_mstate             r_state;
    t_word               r_a;
    t_word               r_b;
    t_word               r_ll;
    logic [HALF_W-1:0]   r_c1;
    logic [HALF_W-1:0]   r_c2;
    t_word               r_prod;
    logic                r_done;

    logic [HALF_W-1:0]   mul_a;
    logic [HALF_W-1:0]   mul_b;
    logic [WORD_W-1:0]   mul_p;
    logic [HALF_W-1:0]   cross_sum;

    // operand selection for the shared multiplier
    always_comb begin
        unique case (r_state)
            M_LH: begin
                mul_a = r_a[HALF_W-1:0];
                mul_b = r_b[WORD_W-1:HALF_W];
            end
            M_HL: begin
                mul_a = r_a[WORD_W-1:HALF_W];
                mul_b = r_b[HALF_W-1:0];
            end
            default: begin
                mul_a = r_a[HALF_W-1:0];
                mul_b = r_b[HALF_W-1:0];
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign cross_sum = r_c1 + r_c2;

    // sequencer, partial products and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_a     <= i_req.a;
                        r_b     <= i_req.b;
                        r_state <= M_LL;
                    end
                end
                M_LL: begin
                    r_ll    <= mul_p;
                    r_state <= M_LH;
                end
                M_LH: begin
                    r_c1    <= mul_p[HALF_W-1:0];
                    r_state <= M_HL;
                end
                M_HL: begin
                    r_c2    <= mul_p[HALF_W-1:0];
                    r_state <= M_SUM;
                end
                M_SUM: begin
                    r_prod  <= r_ll + {cross_sum, {HALF_W{1'b0}}};
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_prod;

endmodule

### tb/structure_constant_algebra_multiply_unit_test.sv
// ----------------------------------------------------------------------------
// structure_constant_algebra_multiply_unit_test: self-checking bench
// Loads structure constant tables through write items and checks every
// product item against a shadow table and an in-bench product calculation,
// under directed corners, random traffic with several idling mixes and a
// long result hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module structure_constant_algebra_multiply_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import scam_pkg::*;

    // run limits
    localparam int LIMIT_CYCLES = 5_000_000;
    localparam int DRAIN_CYCLES = 1200;
    localparam int HOLD_CYCLES  = 3000;
    localparam int PHASE_ITEMS  = 375;
    localparam int MAX_REPORTS  = 10;

    typedef logic [NFIELDS-1:0][WORD_W-1:0] t_coords;

    // one input item as the bench builds it
    typedef struct packed {
        logic             func;
        logic [IDX_W-1:0] coef_index;
        t_word            coef_value;
        t_coords          x;
        t_coords          y;
    } t_scam_item;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    scam_in_if  in_ch ();
    scam_out_if res_ch ();

    structure_constant_algebra_multiply_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_res   (res_ch.source)
    );

    // shadow of the coefficient table and products still to arrive
    t_word   coef_shadow [TABLE_SIZE];
    t_coords product_q [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int err_count      = 0;
    int cycle_count    = 0;

    logic hold_toggle = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d products outstanding",
                     cycle_count, product_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // error count, only the first few are printed
    function automatic void flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endfunction

    // product r_i = sum over j,k of x_j*y_k*c[j][k][i], all modulo 2^64
    function automatic t_coords compute_product(input t_scam_item it);
        t_word   xv  [DIM];
        t_word   yv  [DIM];
        t_word   acc [DIM];
        t_word   term;
        t_coords r;
        for (int i = 0; i < DIM; i++) begin
            xv[i]  = '0;
            yv[i]  = '0;
            acc[i] = '0;
            if (i < NFIELDS) begin
                xv[i] = it.x[i];
                yv[i] = it.y[i];
            end
        end
        for (int j = 0; j < DIM; j++) begin
            for (int k = 0; k < DIM; k++) begin
                term = xv[j] * yv[k];
                for (int i = 0; i < DIM; i++)
                    acc[i] = acc[i] + term * coef_shadow[(j * DIM + k) * DIM + i];
            end
        end
        r = '0;
        for (int i = 0; i < NFIELDS && i < DIM; i++)
            r[i] = acc[i];
        return r;
    endfunction

    // update the shadow for an accepted item
    function automatic void track_item(input t_scam_item it);
        if (it.func == FUNC_WRITE) begin
            // writes past the table end are dropped
            if (int'(it.coef_index) < TABLE_SIZE)
                coef_shadow[it.coef_index] = it.coef_value;
        end else begin
            product_q = {product_q, compute_product(it)};
        end
    endfunction

    // word with a bias towards corners
    function automatic t_word rand_word();
        t_word w;
        int    sel;
        sel = $urandom_range(99);
        w   = {$urandom, $urandom};
        if (sel < 15)
            w = t_word'($urandom_range(15));
        else if (sel < 25)
            w = '1;
        else if (sel < 33)
            w = '0;
        else if (sel < 43)
            w = t_word'(1) << $urandom_range(WORD_W - 1);
        else if (sel < 50)
            w = ~t_word'($urandom_range(15));
        return w;
    endfunction

    // item with every field random, function as given
    function automatic t_scam_item noise_item(input logic f);
        t_scam_item it;
        it.func       = f;
        it.coef_index = IDX_W'($urandom);
        it.coef_value = {$urandom, $urandom};
        for (int i = 0; i < NFIELDS; i++) begin
            it.x[i] = {$urandom, $urandom};
            it.y[i] = {$urandom, $urandom};
        end
        return it;
    endfunction

    function automatic t_scam_item write_item(input int idx, input t_word val);
        t_scam_item it;
        it            = noise_item(FUNC_WRITE);
        it.coef_index = IDX_W'(idx);
        it.coef_value = val;
        return it;
    endfunction

    function automatic t_scam_item mul_item(input t_coords xv, input t_coords yv);
        t_scam_item it;
        it   = noise_item(FUNC_MUL);
        it.x = xv;
        it.y = yv;
        return it;
    endfunction

    // operand vector: corner-biased, sometimes a single nonzero coordinate
    function automatic t_coords rand_coords();
        t_coords v;
        int      pick;
        v = '0;
        if ($urandom_range(99) < 15) begin
            pick    = $urandom_range(NFIELDS - 1);
            v[pick] = rand_word();
        end else begin
            for (int i = 0; i < NFIELDS; i++)
                v[i] = rand_word();
        end
        return v;
    endfunction

    // offer one item and wait for it to be taken
    task automatic offer_item(input t_scam_item it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= it.func;
        in_ch.coef_index <= it.coef_index;
        in_ch.coef_value <= it.coef_value;
        in_ch.x_0        <= it.x[0];
        in_ch.x_1        <= it.x[1];
        in_ch.x_2        <= it.x[2];
        in_ch.x_3        <= it.x[3];
        in_ch.y_0        <= it.y[0];
        in_ch.y_1        <= it.y[1];
        in_ch.y_2        <= it.y[2];
        in_ch.y_3        <= it.y[3];
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        track_item(it);
    endtask

    // result side: random stalls, long hold-off, compare with oldest product
    always @(posedge clk) begin
        t_coords got;
        t_coords want;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                got = {res_ch.r_3, res_ch.r_2, res_ch.r_1, res_ch.r_0};
                if (product_q.size() == 0) begin
                    flag_error($sformatf("unexpected result item %h", got));
                end else begin
                    want = product_q.pop_front();
                    for (int i = 0; i < NFIELDS; i++) begin
                        if (got[i] !== want[i])
                            flag_error($sformatf("r_%0d expected %h got %h",
                                                 i, want[i], got[i]));
                    end
                end
            end
            res_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted down once per cycle
    always @(posedge clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // corners of the table and the operands, no idling
    task automatic test_table_corners();
        t_coords ones;
        t_coords zero;
        t_coords top;
        ones = '1;
        zero = '0;
        top  = '0;
        send_idle_pct  = 0;
        recv_stall_pct <= 0;
        // table cleared by reset gives a zero product
        offer_item(mul_item(ones, ones));
        offer_item(write_item(0, '1));
        offer_item(write_item(TABLE_SIZE - 1, '1));
        offer_item(write_item(21, 64'd1));
        offer_item(write_item(42, 64'h8000_0000_0000_0000));
        offer_item(mul_item(ones, ones));
        top[0] = '1;
        offer_item(mul_item(top, top));
        top    = '0;
        top[NFIELDS-1] = '1;
        offer_item(mul_item(top, ones));
        offer_item(mul_item(zero, ones));
        offer_item(mul_item(ones, zero));
        // overwrite an entry
        offer_item(write_item(0, '0));
        offer_item(write_item(1, 64'd1));
        offer_item(write_item(4, 64'd3));
        offer_item(write_item(16, 64'hFFFF_FFFF_FFFF_FFFE));
        offer_item(write_item(TABLE_SIZE - 1, 64'h7FFF_FFFF_FFFF_FFFF));
        top = {64'h8000_0000_0000_0001, 64'hFFFF_FFFF_0000_0000,
               64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
        offer_item(mul_item(top, ones));
        offer_item(mul_item(ones, top));
        offer_item(mul_item(top, top));
        offer_item(write_item(TABLE_SIZE - 1, '0));
        offer_item(mul_item(ones, ones));
    endtask

    // random table loads and products under one idling mix
    task automatic test_random_traffic(input int n_items, input int send_pct,
                                       input int recv_pct);
        int    sent;
        int    n_wr;
        int    n_mul;
        int    sel;
        int    kind;
        t_word val;
        send_idle_pct  = send_pct;
        recv_stall_pct <= recv_pct;
        sent = 0;
        while (sent < n_items) begin
            sel = $urandom_range(99);
            if (sel < 3) begin
                // whole table reload: dense, sparse or each entry one or all ones
                kind = $urandom_range(2);
                for (int idx = 0; idx < TABLE_SIZE; idx++) begin
                    val = rand_word();
                    if (kind == 1 && $urandom_range(99) < 80)
                        val = '0;
                    else if (kind == 2)
                        val = ($urandom_range(1) != 0) ? t_word'(1) : ~t_word'(0);
                    offer_item(write_item(idx, val));
                end
                sent += TABLE_SIZE;
            end else if (sel < 83) begin
                // a few entry updates, then products
                n_wr  = $urandom_range(6);
                n_mul = $urandom_range(1, 2);
                repeat (n_wr)
                    offer_item(write_item($urandom_range(TABLE_SIZE - 1), rand_word()));
                repeat (n_mul)
                    offer_item(mul_item(rand_coords(), rand_coords()));
                sent += n_wr + n_mul;
            end else begin
                // noise: any function, every field random
                offer_item(noise_item(logic'($urandom_range(1))));
                sent++;
            end
        end
    endtask

    // receiver holds off long while items keep coming, input must stall
    task automatic test_result_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct <= 0;
        hold_toggle    <= ~hold_toggle;
        offer_item(write_item($urandom_range(TABLE_SIZE - 1), rand_word()));
        offer_item(write_item($urandom_range(TABLE_SIZE - 1), rand_word()));
        offer_item(mul_item(rand_coords(), rand_coords()));
        offer_item(write_item($urandom_range(TABLE_SIZE - 1), rand_word()));
        offer_item(mul_item(rand_coords(), rand_coords()));
        offer_item(mul_item(rand_coords(), rand_coords()));
        repeat (6)
            offer_item(noise_item(logic'($urandom_range(1))));
    endtask

    // sequence of tests
    initial begin
        in_ch.valid      = 1'b0;
        in_ch.func       = FUNC_WRITE;
        in_ch.coef_index = '0;
        in_ch.coef_value = '0;
        in_ch.x_0        = '0;
        in_ch.x_1        = '0;
        in_ch.x_2        = '0;
        in_ch.x_3        = '0;
        in_ch.y_0        = '0;
        in_ch.y_1        = '0;
        in_ch.y_2        = '0;
        in_ch.y_3        = '0;
        for (int i = 0; i < TABLE_SIZE; i++)
            coef_shadow[i] = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_corners();
        test_random_traffic(PHASE_ITEMS, 0, 0);
        test_random_traffic(PHASE_ITEMS, 56, 0);
        test_random_traffic(PHASE_ITEMS, 0, 56);
        test_random_traffic(PHASE_ITEMS, 38, 38);
        test_result_backpressure();

        // drain
        in_ch.valid <= 1'b0;
        while (product_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (product_q.size() != 0)
            flag_error($sformatf("%0d products never arrived", product_q.size()));

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
design/scam_pkg.sv
design/scam_if.sv
design/scam_mul64.sv
design/structure_constant_algebra_multiply_unit.sv
tb/structure_constant_algebra_multiply_unit_test.sv
